// ----- hw/rtl/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants
// Instruction kinds, error codes, stage latch layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package msp_pkg;

  typedef enum logic [2:0] {
    K_ADD  = 3'd0,
    K_SUB  = 3'd1,
    K_MUL  = 3'd2,
    K_ADDI = 3'd3,
    K_BEQ  = 3'd4,
    K_LW   = 3'd5,
    K_SW   = 3'd6,
    K_HALT = 3'd7
  } kind_e;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_IMM  = 2'd1;
  localparam logic [1:0] ERR_ALGN = 2'd2;

  localparam logic [1:0] CFG_MUL = 2'd0;
  localparam logic [1:0] CFG_ALU = 2'd1;
  localparam logic [1:0] CFG_MEM = 2'd2;

  localparam logic [1:0] BR_IDLE = 2'd0;
  localparam logic [1:0] BR_WAIT = 2'd1;
  localparam logic [1:0] BR_DONE = 2'd2;

  localparam int PC_MAX = 511;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
  } instr_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [8:0]  pc;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
  } latch_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_OUT  = 2'd2
  } seq_e;

  function automatic logic [5:0] dest_of(input latch_t l);
    logic [5:0] r;
    r = 6'h20;
    case (l.kind)
      K_ADD, K_SUB, K_MUL: r = {1'b0, l.rd};
      K_ADDI, K_LW:        r = {1'b0, l.rt};
      default:             r = 6'h20;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mips_subset_pipeline_unit.sv -----
// ----------------------------------------------------------------------------
// mips_subset_pipeline_unit: five-stage MIPS subset pipeline simulator
// Executes loaded instructions one modeled clock tick per cmd 1 input transaction.
// ----------------------------------------------------------------------------
// Usage: each input transaction on s_axis carries cmd in tuser. cmd 0 loads
// one instruction into the instruction store; cmd 1 advances the modeled
// pipeline by one tick (write-back, memory, execute, decode, fetch). Every
// input transaction yields exactly one output transaction on m_axis holding
// the register write of that tick (if any) plus halted and error status.
// Timing: a transaction passes the sequencer states S_IDLE, which issues
// synchronous reads of the instruction, data and register memories, S_READ,
// which evaluates the tick and writes back, and S_OUT, which holds the result
// in the output register. The next transaction is taken once the output
// register is free, so no new item is taken before the last one is through.
// Reset: the register file and data store are zeroed by a clearing pass
// over max(DMEM_DEPTH, 32) entries after reset, during which s_axis_tready is
// low. Configuration writes take effect at once and belong between
// transactions, while nothing is in flight. When the receiver stalls,
// the result waits in the output register and no new item is taken.
// The instruction store is not cleared; fetching an unloaded slot is
// undefined.
// ----------------------------------------------------------------------------
`default_nettype none
module mips_subset_pipeline_unit import msp_pkg::*; #(
  parameter int IMEM_DEPTH = 512,
  parameter int DMEM_DEPTH = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: load_addr[8:0], instr_kind[11:9], rd[16:12], rs[21:17],
  // rt[26:22], imm[42:27], zero fill to 48 bits
  input  wire logic [47:0] s_axis_tdata,
  // tuser: cmd
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: wb_valid[0], wb_reg[5:1], wb_data[37:6], halted[38],
  // error[40:39], zero fill to 48 bits
  output logic      [47:0] m_axis_tdata
);
  localparam int IAW = $clog2(IMEM_DEPTH);
  localparam int DAW = $clog2(DMEM_DEPTH);
  localparam int PCL = (IMEM_DEPTH < 512) ? IMEM_DEPTH - 1 : PC_MAX;
  // The clearing pass must cover the whole register file as well.
  localparam int CLR_N = (DMEM_DEPTH < 32) ? 32 : DMEM_DEPTH;
  localparam int CCW = $clog2(CLR_N) + 1;

  // configuration
  logic [7:0] mul_q, alu_q, memc_q;
  wire  [7:0] mul_e  = (mul_q == 8'd0) ? 8'd1 : mul_q;
  wire  [7:0] alu_e  = (alu_q == 8'd0) ? 8'd1 : alu_q;
  wire  [7:0] memc_e = (memc_q == 8'd0) ? 8'd1 : memc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= 8'd1; alu_q <= 8'd1; memc_q <= 8'd4;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MUL) mul_q <= cfg_data_i;
      if (cfg_index_i == CFG_ALU) alu_q <= cfg_data_i;
      if (cfg_index_i == CFG_MEM) memc_q <= cfg_data_i;
    end
  end

  // pipeline state
  latch_t      lat_q [4];
  latch_t      lat_d [4];
  logic [8:0]  pc_q, pc_d;
  logic [7:0]  fcnt_q, fcnt_d, ecnt_q, ecnt_d, mcnt_q, mcnt_d;
  logic [1:0]  br_q, br_d;
  logic        halt_q, halt_d;
  logic [1:0]  err_q, err_d;

  // sequencer and clearing pass
  seq_e        st_q, st_d;
  logic        clr_q;
  logic [CCW-1:0] ccnt_q;
  logic        cmd_q;

  // memories
  instr_t      imem [IMEM_DEPTH];
  instr_t      irdata_q;
  instr_t      ld_w;
  logic [31:0] dmem [DMEM_DEPTH];
  logic [31:0] drdata_q;

  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd, rf_a, rf_b;

  wire in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == S_IDLE) && !clr_q;

  // read addresses use current state, taken at accept
  wire [31:0] maddr = lat_q[2].res;
  wire [DAW-1:0] didx = maddr[DAW+1:2];

  // Instruction word of a load transaction, unpacked from the stream fields.
  assign ld_w = {s_axis_tdata[11:9], s_axis_tdata[16:12], s_axis_tdata[21:17],
                 s_axis_tdata[26:22], s_axis_tdata[42:27]};

  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser && (13'(s_axis_tdata[8:0]) < 13'(IMEM_DEPTH))) begin
      imem[IAW'(s_axis_tdata[8:0])] <= ld_w;
    end
    irdata_q <= imem[IAW'(pc_q)];
  end

  logic        dm_we;
  logic [DAW-1:0] dm_wa;
  logic [31:0] dm_wd;
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_wa] <= dm_wd;
    end
    drdata_q <= dmem[didx];
  end

  msp_regfile u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (rf_wa),
    .wdata_i   (rf_wd),
    .raddr_a_i (lat_q[0].rs),
    .raddr_b_i (lat_q[0].rt),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  // tick evaluation, in S_READ
  logic        wbv;
  logic [4:0]  wbr;
  logic [31:0] wbd;
  logic [1:0]  e;
  logic        dbusy_rs, dbusy_rt;
  logic [5:0]  ds, dt, d3;
  logic [31:0] sum;
  logic [63:0] prod;
  logic signed [17:0] tgt;
  logic [2:0]  fk;
  logic        dmw;
  logic [31:0] dmd;

  always_comb begin
    for (int i = 0; i < 4; i++) lat_d[i] = lat_q[i];
    pc_d = pc_q; fcnt_d = fcnt_q; ecnt_d = ecnt_q; mcnt_d = mcnt_q;
    br_d = br_q; halt_d = halt_q; err_d = err_q;
    wbv = 1'b0; wbr = 5'd0; wbd = 32'd0; e = ERR_NONE;
    dmw = 1'b0; dmd = 32'd0;
    sum = 32'd0; prod = 64'd0; tgt = 18'sd0; fk = 3'd0;
    ds = 6'd0; dt = 6'd0; dbusy_rs = 1'b0; dbusy_rt = 1'b0;
    d3 = 6'd0;
    if (cmd_q && !halt_q) begin
      // write-back
      if (lat_d[3].valid) begin
        lat_d[3].valid = 1'b0;
        if (lat_d[3].kind == K_HALT) begin
          halt_d = 1'b1;
        end else begin
          d3 = dest_of(lat_d[3]);
          if (!d3[5] && d3[4:0] != 5'd0) begin
            wbv = 1'b1; wbr = d3[4:0]; wbd = lat_d[3].res;
          end
        end
      end
      if (!halt_d) begin
        // memory
        if (lat_d[2].valid && !lat_d[3].valid) begin
          if (lat_d[2].kind == K_LW || lat_d[2].kind == K_SW) begin
            if (mcnt_d > 8'd1) begin
              mcnt_d = mcnt_d - 8'd1;
            end else if (lat_d[2].res[1:0] != 2'b00) begin
              e = ERR_ALGN;
            end else begin
              lat_d[3] = lat_d[2];
              if (lat_d[2].kind == K_LW) lat_d[3].res = drdata_q;
              else begin dmw = 1'b1; dmd = lat_d[2].b; end
              mcnt_d = memc_e;
              lat_d[2] = '0;
            end
          end else if (lat_d[2].kind == K_HALT) begin
            lat_d[3] = lat_d[2];
          end else begin
            lat_d[3] = lat_d[2];
            lat_d[2] = '0;
          end
        end
        if (e == ERR_NONE) begin
          // execute
          if (!(lat_d[2].valid && lat_d[2].kind == K_HALT) && lat_d[1].valid) begin
            if (ecnt_d > 8'd1) begin
              ecnt_d = ecnt_d - 8'd1;
            end else if (!lat_d[2].valid) begin
              lat_d[2] = lat_d[1];
              sum = lat_d[1].a + {{16{lat_d[1].imm[15]}}, lat_d[1].imm};
              prod = lat_d[1].a * lat_d[1].b;
              case (lat_d[1].kind)
                K_ADD: lat_d[2].res = lat_d[1].a + lat_d[1].b;
                K_SUB: lat_d[2].res = lat_d[1].a - lat_d[1].b;
                K_MUL: lat_d[2].res = prod[31:0];
                K_BEQ: begin
                  if (lat_d[1].a == lat_d[1].b) begin
                    tgt = 18'(signed'(lat_d[1].imm)) + 18'(signed'({1'b0, lat_d[1].pc}))
                          + 18'sd1;
                    if (tgt < 0) pc_d = 9'd0;
                    else if (tgt > 18'(PCL)) pc_d = 9'(PCL);
                    else pc_d = tgt[8:0];
                  end
                  br_d = BR_DONE;
                end
                K_HALT: ;
                default: lat_d[2].res = sum;
              endcase
              // A halt is copied on but also stays behind, freezing the front end.
              if (lat_d[1].kind != K_HALT) lat_d[1] = '0;
            end
          end
          // decode
          if (!(lat_d[1].valid && lat_d[1].kind == K_HALT) && lat_d[0].valid
              && !lat_d[1].valid) begin
            fk = lat_d[0].kind;
            ds = (fk == K_HALT) ? 6'd0 : {1'b0, lat_d[0].rs};
            dt = {1'b0, lat_d[0].rt};
            // busy check uses latches after mem/wb of this tick
            dbusy_rs = (lat_d[2].valid && dest_of(lat_d[2]) == ds) ||
                       (lat_d[3].valid && dest_of(lat_d[3]) == ds);
            dbusy_rt = (lat_d[2].valid && dest_of(lat_d[2]) == dt) ||
                       (lat_d[3].valid && dest_of(lat_d[3]) == dt);
            if (!dbusy_rs && !((fk == K_ADD || fk == K_SUB || fk == K_MUL ||
                                fk == K_BEQ || fk == K_SW) && dbusy_rt)) begin
              if ((fk == K_BEQ || fk == K_ADDI || fk == K_LW || fk == K_SW) &&
                  lat_d[0].imm == 16'h8000) begin
                e = ERR_IMM;
              end else begin
                lat_d[1] = lat_d[0];
                lat_d[1].a = (wbv && wbr == lat_d[0].rs) ? wbd : rf_a;
                lat_d[1].b = (wbv && wbr == lat_d[0].rt) ? wbd : rf_b;
                if (fk == K_HALT) begin
                  ecnt_d = 8'd1;
                end else begin
                  ecnt_d = (fk == K_MUL) ? mul_e : alu_e;
                  if (fk == K_BEQ) br_d = BR_WAIT;
                  lat_d[0] = '0;
                end
              end
            end
          end
          // fetch
          if (e == ERR_NONE && !(lat_d[0].valid && lat_d[0].kind == K_HALT)) begin
            if (!lat_d[0].valid && br_d == BR_IDLE) begin
              if (irdata_q.kind == K_HALT || fcnt_d <= 8'd1) begin
                lat_d[0] = '0;
                lat_d[0].valid = 1'b1;
                lat_d[0].kind = irdata_q.kind;
                lat_d[0].rd = irdata_q.rd;
                lat_d[0].rs = irdata_q.rs;
                lat_d[0].rt = irdata_q.rt;
                lat_d[0].imm = irdata_q.imm;
                lat_d[0].pc = pc_q;
                if (irdata_q.kind != K_HALT) begin
                  if (pc_q < 9'(PCL)) pc_d = pc_q + 9'd1;
                  fcnt_d = memc_e;
                end
              end else begin
                fcnt_d = fcnt_d - 8'd1;
              end
            end else if (br_d == BR_DONE) begin
              br_d = BR_IDLE;
            end
          end
        end
        if (e != ERR_NONE) begin
          err_d = e; halt_d = 1'b1;
        end
      end
    end
  end

  // A cleared latch must not look like halt. Valid-less latches with kind
  // bits zero decode as add, which only matters through dest_of when valid.
  // The halt check in exec/decode/fetch also requires valid, matching the
  // model since a cleared latch never carries the halt kind.

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (in_acc) st_d = S_READ;
      S_READ: st_d = S_OUT;
      S_OUT:  if (m_axis_tready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign rf_we = clr_q || (st_q == S_READ && wbv);
  assign rf_wa = clr_q ? ccnt_q[4:0] : wbr;
  assign rf_wd = clr_q ? 32'd0 : wbd;
  assign dm_we = clr_q || (st_q == S_READ && dmw);
  assign dm_wa = clr_q ? ccnt_q[DAW-1:0] : didx;
  assign dm_wd = clr_q ? 32'd0 : dmd;

  logic [40:0] out_q;
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata  = {7'd0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; clr_q <= 1'b1; ccnt_q <= '0; cmd_q <= 1'b0;
      for (int i = 0; i < 4; i++) lat_q[i] <= '0;
      pc_q <= '0; fcnt_q <= 8'd4; ecnt_q <= '0; mcnt_q <= 8'd4;
      br_q <= BR_IDLE; halt_q <= 1'b0; err_q <= ERR_NONE; out_q <= '0;
    end else begin
      st_q <= st_d;
      if (clr_q) begin
        ccnt_q <= ccnt_q + CCW'(1);
        if (ccnt_q == CCW'(CLR_N - 1)) clr_q <= 1'b0;
      end
      if (in_acc) cmd_q <= s_axis_tuser;
      if (st_q == S_READ) begin
        for (int i = 0; i < 4; i++) lat_q[i] <= lat_d[i];
        pc_q <= pc_d; fcnt_q <= fcnt_d; ecnt_q <= ecnt_d; mcnt_q <= mcnt_d;
        br_q <= br_d; halt_q <= halt_d; err_q <= err_d;
        out_q <= {err_d, halt_d, wbd, wbr, wbv};
      end
    end
  end

  // A result is only offered in the output state and never while clearing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !clr_q) else $error("output during clear");
  // Once halted, halt stays set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt dropped");
  // An error code implies the halted status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ERR_NONE |-> halt_q) else $error("error without halt");
endmodule
`default_nettype wire

// ----- hw/rtl/msp_regfile.sv -----
// ----------------------------------------------------------------------------
// msp_regfile: register file memory
// Two synchronous read ports and one write port; reads registered.
// ----------------------------------------------------------------------------
`default_nettype none
module msp_regfile import msp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [4:0]  waddr_i,
  input  wire logic [31:0] wdata_i,
  input  wire logic [4:0]  raddr_a_i,
  input  wire logic [4:0]  raddr_b_i,
  output logic      [31:0] rdata_a_o,
  output logic      [31:0] rdata_b_o
);
  logic [31:0] mem [32];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end
endmodule
`default_nettype wire
